@@ sv/peps_pkg.sv @@
// Shared types and register codes of the pitch edit point selector.
`timescale 1ns / 1ps
`default_nettype none

package peps_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_INTERVAL       = 2'd0;
    localparam logic [1:0] REG_GRADIENT_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_CONFIDENCE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] FRAME_INTERVAL_RST       = 16'd10;
    localparam logic [15:0] GRADIENT_THRESHOLD_RST   = 16'd160;
    localparam logic [7:0]  CONFIDENCE_THRESHOLD_RST = 8'd128;

    // One decision on one frame
    typedef struct packed {
        logic [15:0] frame_index;
        logic        keep;
        logic        run_last;
        logic        sequence_end;
    } result_t;

endpackage

`default_nettype wire

@@ sv/pitch_edit_point_selector.sv @@
// Top level of the pitch edit point selector: frame window, decisions, result queue.
`timescale 1ns / 1ps
`default_nettype none

// The first result of a request shows on the outputs in the cycle after acceptance.
// Throughput: one frame per cycle while each request yields at most one result and out_stall
// is low; a final frame yields up to three results, drained one per cycle from the result
// queue while out_stall is low, and the next request waits until the last is being taken.
// Reset (rst_n low, asynchronous) clears the frame window, the counters and the queue
// and loads the register defaults; the window also clears itself after every final frame.
module pitch_edit_point_selector #(
    parameter int MAX_FRAMES = 65536,
    parameter int FREQ_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [FREQ_BITS-1:0] frequency,
    input  wire logic [7:0]           confidence,
    input  wire logic                 final_frame,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [15:0]               frame_index,
    output logic                      keep,
    output logic                      run_last,
    output logic                      sequence_end,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int CW = (FREQ_BITS > 16) ? FREQ_BITS : 16;
    localparam logic [15:0] LAST_IDX = 16'(MAX_FRAMES - 1);

    // Configuration registers
    logic [15:0] frame_interval_reg;
    logic [15:0] gradient_threshold_reg;
    logic [7:0]  confidence_threshold_reg;

    // Frame window: entry 0 is the newest
    logic [FREQ_BITS-1:0] freq_hist_reg [2];
    logic [1:0]           conf_hist_reg;
    logic [1:0]           uni_hist_reg;
    logic [1:0]           jump_hist_reg;
    logic [15:0]          frame_count_reg;
    logic [15:0]          phase_count_reg;

    // Result queue
    peps_pkg::result_t pend_reg [3];
    logic [1:0]        count_reg;

    logic              accept;
    logic              pop;
    logic              conf_now;
    logic              jump_prev;
    logic              has_a;
    logic              has_b;
    logic [CW-1:0]     gt_w;
    logic [CW-1:0]     step_old;
    logic [CW-1:0]     step_new;
    logic [15:0]       phase_inc;
    peps_pkg::result_t res_a;
    peps_pkg::result_t res_b;
    peps_pkg::result_t res_c;
    peps_pkg::result_t list_next [3];
    logic [1:0]        list_count;

    function automatic logic [FREQ_BITS-1:0] abs_step(
        input logic [FREQ_BITS-1:0] a,
        input logic [FREQ_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign in_stall  = (count_reg > 2'd1) || ((count_reg == 2'd1) && out_stall);
    assign accept    = in_valid && !in_stall;

    assign frame_index  = pend_reg[0].frame_index;
    assign keep         = pend_reg[0].keep;
    assign run_last     = pend_reg[0].run_last;
    assign sequence_end = pend_reg[0].sequence_end;

    // Decide the pending frames
    always_comb
    begin
        conf_now  = (confidence >= confidence_threshold_reg);
        gt_w      = CW'(gradient_threshold_reg);
        step_old  = CW'(abs_step(freq_hist_reg[0], freq_hist_reg[1]));
        step_new  = CW'(abs_step(frequency, freq_hist_reg[0]));
        has_a     = (frame_count_reg >= 16'd2);
        has_b     = final_frame && (frame_count_reg >= 16'd1);
        jump_prev = has_a && conf_hist_reg[0] && ((step_old > gt_w) || (step_new > gt_w));

        res_a.frame_index  = frame_count_reg - 16'd2;
        res_a.keep         = conf_hist_reg[1] &&
                             (uni_hist_reg[1] || jump_hist_reg[1] ||
                              jump_hist_reg[0] || jump_prev);
        res_a.run_last     = !final_frame;
        res_a.sequence_end = 1'b0;

        res_b.frame_index  = frame_count_reg - 16'd1;
        res_b.keep         = conf_hist_reg[0] &&
                             (uni_hist_reg[0] || jump_hist_reg[0] || jump_prev);
        res_b.run_last     = 1'b0;
        res_b.sequence_end = 1'b0;

        res_c.frame_index  = frame_count_reg;
        res_c.keep         = conf_now;
        res_c.run_last     = 1'b1;
        res_c.sequence_end = 1'b1;

        // Pack the results in index order
        list_next[0] = res_c;
        list_next[1] = res_c;
        list_next[2] = res_c;
        list_count   = 2'd1;
        if (!final_frame)
        begin
            list_next[0] = res_a;
            list_count   = has_a ? 2'd1 : 2'd0;
        end
        else if (has_a)
        begin
            list_next[0] = res_a;
            list_next[1] = res_b;
            list_count   = 2'd3;
        end
        else if (has_b)
        begin
            list_next[0] = res_b;
            list_count   = 2'd2;
        end

        phase_inc = phase_count_reg + 16'd1;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_interval_reg       <= peps_pkg::FRAME_INTERVAL_RST;
            gradient_threshold_reg   <= peps_pkg::GRADIENT_THRESHOLD_RST;
            confidence_threshold_reg <= peps_pkg::CONFIDENCE_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                peps_pkg::REG_FRAME_INTERVAL:       frame_interval_reg <= cfg_data;
                peps_pkg::REG_GRADIENT_THRESHOLD:   gradient_threshold_reg <= cfg_data;
                peps_pkg::REG_CONFIDENCE_THRESHOLD: confidence_threshold_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Advance the frame window, clear it after a final frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_hist_reg[0] <= '0;
            freq_hist_reg[1] <= '0;
            conf_hist_reg    <= '0;
            uni_hist_reg     <= '0;
            jump_hist_reg    <= '0;
            frame_count_reg  <= '0;
            phase_count_reg  <= '0;
        end
        else if (accept)
        begin
            if (final_frame)
            begin
                freq_hist_reg[0] <= '0;
                freq_hist_reg[1] <= '0;
                conf_hist_reg    <= '0;
                uni_hist_reg     <= '0;
                jump_hist_reg    <= '0;
                frame_count_reg  <= '0;
                phase_count_reg  <= '0;
            end
            else
            begin
                freq_hist_reg[0] <= frequency;
                freq_hist_reg[1] <= freq_hist_reg[0];
                conf_hist_reg    <= {conf_hist_reg[0], conf_now};
                uni_hist_reg     <= {uni_hist_reg[0], (phase_count_reg == 16'd0)};
                jump_hist_reg    <= {jump_hist_reg[0], jump_prev};
                if (frame_count_reg != LAST_IDX)
                begin
                    frame_count_reg <= frame_count_reg + 16'd1;
                end
                phase_count_reg <= (phase_inc >= frame_interval_reg) ? 16'd0 : phase_inc;
            end
        end
    end

    // Track queue fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= list_count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Load or shift the queued results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg[0] <= list_next[0];
            pend_reg[1] <= list_next[1];
            pend_reg[2] <= list_next[2];
        end
        else if (pop)
        begin
            pend_reg[0] <= pend_reg[1];
            pend_reg[1] <= pend_reg[2];
        end
    end

endmodule

`default_nettype wire

@@ test/edit_point_checker.sv @@
// Decision predictor and result checker for the pitch edit point selector.
`timescale 1ns / 1ps

module edit_point_checker #(
    parameter int MAX_FRAMES = 65536,
    parameter int FREQ_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [FREQ_BITS-1:0] frequency,
    input  wire logic [7:0]           confidence,
    input  wire logic                 final_frame,

    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [15:0]          frame_index,
    input  wire logic                 keep,
    input  wire logic                 run_last,
    input  wire logic                 sequence_end,

    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,

    output int                        fail_count,
    output int                        pending_count
);

    // Register copies
    logic [15:0] interval_reg;
    logic [15:0] gradient_reg;
    logic [7:0]  conf_thresh_reg;

    // Frame window, entry 0 is the newest frame
    logic [FREQ_BITS-1:0] freq_hist [2];
    logic                 conf_hist [2];
    logic                 uni_hist  [2];
    logic                 jump_hist [2];
    logic [15:0]          frame_count;
    logic [15:0]          phase_count;

    peps_pkg::result_t expected_decisions [$];

    // Drop the window back to the start of a sequence
    task automatic clear_window;
        for (int k = 0; k < 2; k++)
        begin
            freq_hist[k] = '0;
            conf_hist[k] = 1'b0;
            uni_hist[k]  = 1'b0;
            jump_hist[k] = 1'b0;
        end
        frame_count = '0;
        phase_count = '0;
    endtask

    // Work out the decisions caused by one accepted frame request
    task automatic decide_frame(input logic [FREQ_BITS-1:0] freq, input logic [7:0] conf,
                                input logic fin);
        logic                 conf_now;
        logic                 uni_now;
        logic                 jump_prev;
        logic [FREQ_BITS-1:0] step_back;
        logic [FREQ_BITS-1:0] step_fwd;
        peps_pkg::result_t    r;
        conf_now = conf >= conf_thresh_reg;
        uni_now  = phase_count == 16'd0;
        step_back = freq_hist[0] > freq_hist[1] ? freq_hist[0] - freq_hist[1]
                                                : freq_hist[1] - freq_hist[0];
        step_fwd  = freq > freq_hist[0] ? freq - freq_hist[0] : freq_hist[0] - freq;
        // The middle frame is a jump only with frames on both sides
        jump_prev = frame_count >= 16'd2 && conf_hist[0] &&
                    (step_back > gradient_reg || step_fwd > gradient_reg);

        if (frame_count >= 16'd2)
        begin
            r.frame_index  = frame_count - 16'd2;
            r.keep         = conf_hist[1] &&
                             (uni_hist[1] || jump_hist[1] || jump_hist[0] || jump_prev);
            r.run_last     = !fin;
            r.sequence_end = 1'b0;
            expected_decisions.push_back(r);
        end

        if (fin)
        begin
            // Flush the frames still pending, then the final frame itself
            if (frame_count >= 16'd1)
            begin
                r.frame_index  = frame_count - 16'd1;
                r.keep         = conf_hist[0] && (uni_hist[0] || jump_hist[0] || jump_prev);
                r.run_last     = 1'b0;
                r.sequence_end = 1'b0;
                expected_decisions.push_back(r);
            end
            r.frame_index  = frame_count;
            r.keep         = conf_now;
            r.run_last     = 1'b1;
            r.sequence_end = 1'b1;
            expected_decisions.push_back(r);
            clear_window();
        end
        else
        begin
            // Shift the window and advance the counters
            freq_hist[1] = freq_hist[0];
            freq_hist[0] = freq;
            conf_hist[1] = conf_hist[0];
            conf_hist[0] = conf_now;
            uni_hist[1]  = uni_hist[0];
            uni_hist[0]  = uni_now;
            jump_hist[1] = jump_hist[0];
            jump_hist[0] = jump_prev;
            if (int'(frame_count) < MAX_FRAMES - 1)
                frame_count = frame_count + 16'd1;
            phase_count = phase_count + 16'd1;
            if (phase_count >= interval_reg)
                phase_count = '0;
        end
    endtask

    task automatic report_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        peps_pkg::result_t want;
        if (!rst_n)
        begin
            interval_reg    = peps_pkg::FRAME_INTERVAL_RST;
            gradient_reg    = peps_pkg::GRADIENT_THRESHOLD_RST;
            conf_thresh_reg = peps_pkg::CONFIDENCE_THRESHOLD_RST;
            clear_window();
            expected_decisions.delete();
            fail_count = 0;
            pending_count <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    peps_pkg::REG_FRAME_INTERVAL:       interval_reg    = cfg_data;
                    peps_pkg::REG_GRADIENT_THRESHOLD:   gradient_reg    = cfg_data;
                    peps_pkg::REG_CONFIDENCE_THRESHOLD: conf_thresh_reg = cfg_data[7:0];
                    default: ;
                endcase
            end

            // Compare each taken decision with the oldest one predicted
            if (out_valid && !out_stall)
            begin
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t unexpected decision: expected none actual frame %0d keep %0b",
                             $time, frame_index, keep);
                    fail_count++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    report_field("frame_index", want.frame_index, frame_index);
                    report_field("keep", want.keep, keep);
                    report_field("run_last", want.run_last, run_last);
                    report_field("sequence_end", want.sequence_end, sequence_end);
                end
            end

            // Predict from each accepted frame request
            if (in_valid && !in_stall)
                decide_frame(frequency, confidence, final_frame);

            pending_count <= expected_decisions.size();
        end
    end

endmodule

@@ test/pitch_edit_point_selector_test.sv @@
// Stimulus and verdict for the pitch edit point selector.
`timescale 1ns / 1ps

module pitch_edit_point_selector_test;

    localparam int MAX_FRAMES = 65536;
    localparam int FREQ_BITS  = 16;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FREQ_BITS-1:0] frequency = '0;
    logic [7:0]           confidence = '0;
    logic                 final_frame = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [15:0]          frame_index;
    logic                 keep;
    logic                 run_last;
    logic                 sequence_end;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    int fail_count;
    int pending_count;

    // Idling mix, percent of cycles
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Long receiver hold-off requests
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // Random sequence state
    int seq_left = 0;
    int walk_freq = 1600;
    int cur_gradient = peps_pkg::GRADIENT_THRESHOLD_RST;
    int cur_conf_thr = peps_pkg::CONFIDENCE_THRESHOLD_RST;

    pitch_edit_point_selector #(
        .MAX_FRAMES(MAX_FRAMES),
        .FREQ_BITS (FREQ_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frequency   (frequency),
        .confidence  (confidence),
        .final_frame (final_frame),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_index (frame_index),
        .keep        (keep),
        .run_last    (run_last),
        .sequence_end(sequence_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    edit_point_checker #(
        .MAX_FRAMES(MAX_FRAMES),
        .FREQ_BITS (FREQ_BITS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frequency    (frequency),
        .confidence   (confidence),
        .final_frame  (final_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_index  (frame_index),
        .keep         (keep),
        .run_last     (run_last),
        .sequence_end (sequence_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always #5 clk = ~clk;

    // Drive the receiver stall: long hold-offs first, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= $urandom_range(99) < stall_pct;
    end

    // Offer one frame request and hold it until accepted
    task automatic send_frame(input logic [FREQ_BITS-1:0] freq, input logic [7:0] conf,
                              input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        frequency   <= freq;
        confidence  <= conf;
        final_frame <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted decision has come out
    task automatic wait_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int interval, input int gradient, input int conf_thr);
        write_reg(peps_pkg::REG_FRAME_INTERVAL, interval[15:0]);
        write_reg(peps_pkg::REG_GRADIENT_THRESHOLD, gradient[15:0]);
        write_reg(peps_pkg::REG_CONFIDENCE_THRESHOLD, {8'd0, conf_thr[7:0]});
        cur_gradient = gradient;
        cur_conf_thr = conf_thr;
    endtask

    // Mostly well-formed sequences that walk around the thresholds, some noise
    task automatic run_random(input int count);
        int   step;
        int   conf_v;
        logic fin;
        repeat (count)
        begin
            if (seq_left == 0)
                seq_left = ($urandom_range(3) == 0) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 40);
            seq_left--;
            fin = seq_left == 0;
            if ($urandom_range(99) < 15)
            begin
                // Noise: any value, final mark at random
                walk_freq = $urandom_range(65535);
                conf_v    = $urandom_range(255);
                fin       = $urandom_range(7) == 0;
                if (fin)
                    seq_left = 0;
            end
            else
            begin
                case ($urandom_range(3))
                    0: step = $urandom_range(cur_gradient / 2);
                    1: step = cur_gradient + $urandom_range(2) - 1;
                    2: step = $urandom_range(65535);
                    default: step = 0;
                endcase
                if ($urandom_range(1))
                    step = -step;
                walk_freq = (walk_freq + step) & 16'hFFFF;
                case ($urandom_range(3))
                    0: conf_v = $urandom_range(255);
                    1: conf_v = cur_conf_thr + $urandom_range(2) - 1;
                    default: conf_v = $urandom_range(255, cur_conf_thr);
                endcase
                if (conf_v < 0)
                    conf_v = 0;
                if (conf_v > 255)
                    conf_v = 255;
            end
            send_frame(walk_freq[FREQ_BITS-1:0], conf_v[7:0], fin);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An unknown register index must leave the defaults alone
        write_reg(REG_UNUSED, 16'h0001);

        // Single final frame, then two and three frame sequences
        send_frame(16'd100, 8'd200, 1'b1);
        send_frame(16'd0, 8'd255, 1'b0);
        send_frame(16'hFFFF, 8'd255, 1'b1);
        send_frame(16'd1000, 8'd255, 1'b0);
        send_frame(16'd1000, 8'd127, 1'b0);
        send_frame(16'd1000, 8'd128, 1'b1);

        // Steps just above, at and below the gradient threshold, extremes
        send_frame(16'd1600, 8'd200, 1'b0);
        send_frame(16'd1600, 8'd200, 1'b0);
        send_frame(16'd1761, 8'd200, 1'b0);
        send_frame(16'd1761, 8'd200, 1'b0);
        send_frame(16'd1601, 8'd200, 1'b0);
        send_frame(16'd1760, 8'd0, 1'b0);
        send_frame(16'd1601, 8'd200, 1'b0);
        send_frame(16'hFFFF, 8'd255, 1'b0);
        send_frame(16'd0, 8'd255, 1'b0);
        send_frame(16'd0, 8'd0, 1'b0);
        send_frame(16'd5, 8'd130, 1'b0);
        send_frame(16'd5, 8'd130, 1'b0);
        send_frame(16'd5, 8'd130, 1'b0);
        send_frame(16'd5, 8'd130, 1'b0);
        send_frame(16'd5, 8'd130, 1'b1);
        wait_idle();

        // Default settings, no idling
        run_random(PHASE_ITEMS);
        wait_idle();

        // Interval of one, smallest thresholds, sender idling
        set_config(1, 0, 0);
        send_idle_pct = 68;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Largest interval and thresholds, receiver stalling
        set_config(65535, 65535, 255);
        send_idle_pct = 0;
        stall_pct = 68;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Zero interval, both sides idling, with a long hold-off to fill the block
        set_config(0, 50, 100);
        send_idle_pct = 19;
        stall_pct = 19;
        hold_requests++;
        run_random(PHASE_ITEMS);
        wait_idle();

        // Change the interval in the middle of a sequence
        set_config(3, 300, 128);
        send_idle_pct = 0;
        stall_pct = 0;
        run_random(PHASE_ITEMS / 2);
        wait_idle();
        write_reg(peps_pkg::REG_FRAME_INTERVAL, 16'd2);
        run_random(PHASE_ITEMS / 2);
        wait_idle();

        set_config(7, 160, 140);
        send_idle_pct = 19;
        stall_pct = 19;
        run_random(PHASE_ITEMS);
        wait_idle();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
